// ===== src/hpt_pkg.sv =====
// shared types and constants of the homogeneous point transform
// no dependencies
`default_nettype none
package hpt_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int DEF_WORD_BITS = 32;

	// widest word and widest exact magnitude of a linear sum
	localparam int WORD_MAX = 32;
	localparam int MAG_MAX  = 2 * WORD_MAX + 1;

	localparam int REG_IDX_BITS = 3;
	localparam logic [REG_IDX_BITS-1:0] REG_XX = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_XY = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_XT = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_YX = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_YY = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_YT = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_PP = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_TT = 3'd7;

	typedef struct packed {
		logic [31:0] xx;
		logic [31:0] xy;
		logic [31:0] xt;
		logic [31:0] yx;
		logic [31:0] yy;
		logic [31:0] yt;
		logic [63:0] pp;
		logic [31:0] tt;
	} coef_t;

	// classified request between front and back
	typedef struct packed {
		logic [MAG_MAX-1:0] xmag;
		logic               xneg;
		logic [MAG_MAX-1:0] ymag;
		logic               yneg;
		logic [MAG_MAX-1:0] zmag;
		logic               zneg;
		logic               zero;
		logic               xsat;
		logic               ysat;
	} cls_t;

	typedef struct packed {
		logic [31:0] ox;
		logic [31:0] oy;
		logic        zero;
		logic        ovf;
	} res_t;

endpackage
`default_nettype wire

// ===== src/hpt_queue.sv =====
// small register queue used between front and back and at the result side
// no package dependency
`default_nettype none
module hpt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/hpt_front.sv =====
// front: takes points, forms the three exact linear sums and classifies them
// depends on hpt_pkg
`default_nettype none
module hpt_front #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hpt_pkg::coef_t coef,
	input  wire logic           push,
	input  wire logic [31:0]    pt_x,
	input  wire logic [31:0]    pt_y,
	output logic                full,
	output logic                q_push,
	output hpt_pkg::cls_t       q_data,
	input  wire logic           q_full
);
	import hpt_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 2;
	localparam int MW = 2 * W + 1;
	localparam int SH = W + 1 - F;

	logic signed [W-1:0] x, y, cxx, cxy, cxt, cyx, cyy, cyt, ctx, cty, ctt;
	logic en, accept;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [PW-1:0] pxa_s1, pxb_s1, pya_s1, pyb_s1, pza_s1, pzb_s1;
	logic signed [SW-1:0] sx_s2, sy_s2, sz_s2;
	logic [MW-1:0] xm_s3, ym_s3, zm_s3;
	logic          xn_s3, yn_s3, zn_s3;
	cls_t          cls_s4;

	assign x   = $signed(pt_x[W-1:0]);
	assign y   = $signed(pt_y[W-1:0]);
	assign cxx = $signed(coef.xx[W-1:0]);
	assign cxy = $signed(coef.xy[W-1:0]);
	assign cxt = $signed(coef.xt[W-1:0]);
	assign cyx = $signed(coef.yx[W-1:0]);
	assign cyy = $signed(coef.yy[W-1:0]);
	assign cyt = $signed(coef.yt[W-1:0]);
	assign ctx = $signed(coef.pp[W-1:0]);
	assign cty = $signed(coef.pp[32+W-1:32]);
	assign ctt = $signed(coef.tt[W-1:0]);

	assign en     = !v_s4 || !q_full;
	assign full   = !en;
	assign accept = push && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// products
			pxa_s1 <= x * cxx;
			pxb_s1 <= y * cxy;
			pya_s1 <= x * cyx;
			pyb_s1 <= y * cyy;
			pza_s1 <= x * ctx;
			pzb_s1 <= y * cty;
			// exact sums with the offset term scaled up
			sx_s2 <= SW'(pxa_s1) + SW'(pxb_s1) + (SW'(cxt) <<< F);
			sy_s2 <= SW'(pya_s1) + SW'(pyb_s1) + (SW'(cyt) <<< F);
			sz_s2 <= SW'(pza_s1) + SW'(pzb_s1) + (SW'(ctt) <<< F);
			// sign and magnitude
			xn_s3 <= sx_s2[SW-1];
			yn_s3 <= sy_s2[SW-1];
			zn_s3 <= sz_s2[SW-1];
			xm_s3 <= MW'(sx_s2[SW-1] ? -sx_s2 : sx_s2);
			ym_s3 <= MW'(sy_s2[SW-1] ? -sy_s2 : sy_s2);
			zm_s3 <= MW'(sz_s2[SW-1] ? -sz_s2 : sz_s2);
			// classify: zero divisor, quotient too wide for the divider
			cls_s4.xmag <= MAG_MAX'(xm_s3);
			cls_s4.ymag <= MAG_MAX'(ym_s3);
			cls_s4.zmag <= MAG_MAX'(zm_s3);
			cls_s4.xneg <= xn_s3;
			cls_s4.yneg <= yn_s3;
			cls_s4.zneg <= zn_s3;
			cls_s4.zero <= (zm_s3 == '0);
			cls_s4.xsat <= ((xm_s3 >> SH) >= zm_s3);
			cls_s4.ysat <= ((ym_s3 >> SH) >= zm_s3);
		end
	end

	assign q_push = v_s4 && !q_full;
	assign q_data = cls_s4;
endmodule
`default_nettype wire

// ===== src/hpt_back.sv =====
// back: pipelined restoring divider, one quotient bit per stage, then saturation
// depends on hpt_pkg
`default_nettype none
module hpt_back #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hpt_pkg::cls_t q_data,
	input  wire logic          q_empty,
	output logic               q_pop,
	output logic               r_push,
	output hpt_pkg::res_t      r_data,
	input  wire logic          r_full
);
	import hpt_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int MW = 2 * W + 1;
	localparam int SH = W + 1 - F;
	localparam int QW = W + 1;
	localparam int NS = W + 1;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic zero;
		logic xsat;
		logic ysat;
	} flg_t;

	logic              v_s   [NS+1];
	logic [MW-1:0]     xr_s  [NS+1];
	logic [MW-1:0]     yr_s  [NS+1];
	logic [QW-1:0]     xl_s  [NS+1];
	logic [QW-1:0]     yl_s  [NS+1];
	logic [QW-1:0]     xq_s  [NS+1];
	logic [QW-1:0]     yq_s  [NS+1];
	logic [MW-1:0]     d_s   [NS+1];
	flg_t              f_s   [NS+1];

	logic          en;
	logic [MW-1:0] xn, yn, dz;
	logic [MW+F-1:0] xfull, yfull;

	assign en    = !v_s[NS] || !r_full;
	assign q_pop = en && !q_empty;

	assign xn    = MW'(q_data.xmag);
	assign yn    = MW'(q_data.ymag);
	assign dz    = MW'(q_data.zmag);
	assign xfull = {xn, {F{1'b0}}};
	assign yfull = {yn, {F{1'b0}}};

	// stage 0 is the queue head
	always_comb begin
		v_s[0]       = !q_empty;
		xr_s[0]      = xn >> SH;
		yr_s[0]      = yn >> SH;
		xl_s[0]      = xfull[QW-1:0];
		yl_s[0]      = yfull[QW-1:0];
		xq_s[0]      = '0;
		yq_s[0]      = '0;
		d_s[0]       = dz;
		f_s[0].xneg  = q_data.xneg ^ q_data.zneg;
		f_s[0].yneg  = q_data.yneg ^ q_data.zneg;
		f_s[0].zero  = q_data.zero;
		f_s[0].xsat  = q_data.xsat;
		f_s[0].ysat  = q_data.ysat;
	end

	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [MW:0] xsh, ysh, xdf, ydf;
		logic        xge, yge;

		assign xsh = {xr_s[k], xl_s[k][W-k]};
		assign ysh = {yr_s[k], yl_s[k][W-k]};
		assign xdf = xsh - {1'b0, d_s[k]};
		assign ydf = ysh - {1'b0, d_s[k]};
		assign xge = (xsh >= {1'b0, d_s[k]});
		assign yge = (ysh >= {1'b0, d_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				xr_s[k+1] <= xge ? xdf[MW-1:0] : xsh[MW-1:0];
				yr_s[k+1] <= yge ? ydf[MW-1:0] : ysh[MW-1:0];
				xq_s[k+1] <= {xq_s[k][QW-2:0], xge};
				yq_s[k+1] <= {yq_s[k][QW-2:0], yge};
				xl_s[k+1] <= xl_s[k];
				yl_s[k+1] <= yl_s[k];
				d_s[k+1]  <= d_s[k];
				f_s[k+1]  <= f_s[k];
			end
		end
	end

	// saturation and sign
	localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (W - 1)) - 64'd1);
	localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (W - 1));

	logic [QW-1:0] xlim, ylim, xqs, yqs;
	logic          xov, yov;
	logic [W-1:0]  xv, yv;

	always_comb begin
		xlim = f_s[NS].xneg ? LIM_NEG : LIM_POS;
		ylim = f_s[NS].yneg ? LIM_NEG : LIM_POS;
		xov  = f_s[NS].xsat || (xq_s[NS] > xlim);
		yov  = f_s[NS].ysat || (yq_s[NS] > ylim);
		xqs  = xov ? xlim : xq_s[NS];
		yqs  = yov ? ylim : yq_s[NS];
		xv   = W'(f_s[NS].xneg ? -xqs : xqs);
		yv   = W'(f_s[NS].yneg ? -yqs : yqs);
		if (f_s[NS].zero) begin
			r_data.ox   = '0;
			r_data.oy   = '0;
			r_data.zero = 1'b1;
			r_data.ovf  = 1'b0;
		end else begin
			r_data.ox   = 32'($signed(xv));
			r_data.oy   = 32'($signed(yv));
			r_data.zero = 1'b0;
			r_data.ovf  = xov || yov;
		end
	end

	assign r_push = v_s[NS] && !r_full;
endmodule
`default_nettype wire

// ===== src/homogeneous_point_transform.sv =====
// homogeneous point transform: one point per cycle sustained unless stalled, any
// mix of stalls; path from request to result: four front stages, middle queue,
// WORD_BITS + 1 divider stages, result queue; the divider stages, one quotient bit
// each, set the latency; throughput is one request per cycle unless the result
// side stalls; arst_n clears all control and loads the identity matrix
`default_nettype none
module homogeneous_point_transform #(
	parameter int FRAC_BITS = hpt_pkg::DEF_FRAC_BITS,
	parameter int WORD_BITS = hpt_pkg::DEF_WORD_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write port
	input  wire logic                             wr_en,
	input  wire logic [hpt_pkg::REG_IDX_BITS-1:0] wr_index,
	input  wire logic [63:0]                      wr_data,
	// request side
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [31:0]                      pt_x,
	input  wire logic [31:0]                      pt_y,
	// result side
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [31:0]                           out_x,
	output logic [31:0]                           out_y,
	output logic                                  zero_divisor,
	output logic                                  overflow
);
	import hpt_pkg::*;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// coefficient registers, reset to identity
	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q    <= '0;
			coef_q.xx <= 32'(64'd1 << FRAC_BITS);
			coef_q.yy <= 32'(64'd1 << FRAC_BITS);
			coef_q.tt <= 32'(64'd1 << FRAC_BITS);
		end else if (wr_en) begin
			case (wr_index)
				REG_XX:  coef_q.xx <= wr_data[31:0];
				REG_XY:  coef_q.xy <= wr_data[31:0];
				REG_XT:  coef_q.xt <= wr_data[31:0];
				REG_YX:  coef_q.yx <= wr_data[31:0];
				REG_YY:  coef_q.yy <= wr_data[31:0];
				REG_YT:  coef_q.yt <= wr_data[31:0];
				REG_PP:  coef_q.pp <= wr_data;
				REG_TT:  coef_q.tt <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	// front to back queue
	cls_t mid_in, mid_out;
	logic mid_push, mid_full, mid_pop, mid_empty;

	hpt_front #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef_q),
		.push   (push),
		.pt_x   (pt_x),
		.pt_y   (pt_y),
		.full   (full),
		.q_push (mid_push),
		.q_data (mid_in),
		.q_full (mid_full)
	);

	hpt_queue #(
		.WIDTH($bits(cls_t)),
		.DEPTH(MID_DEPTH)
	) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_out),
		.empty  (mid_empty)
	);

	// back end: divider and saturation
	res_t res_in, res_out;
	logic res_push, res_full;

	hpt_back #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (mid_out),
		.q_empty (mid_empty),
		.q_pop   (mid_pop),
		.r_push  (res_push),
		.r_data  (res_in),
		.r_full  (res_full)
	);

	// result queue decouples the divider from the consumer
	hpt_queue #(
		.WIDTH($bits(res_t)),
		.DEPTH(OUT_DEPTH)
	) u_res (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign out_x        = res_out.ox;
	assign out_y        = res_out.oy;
	assign zero_divisor = res_out.zero;
	assign overflow     = res_out.ovf;
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for homogeneous_point_transform: point requests through a random-gap driver,
// results checked against an exact wide-integer projective transform predictor
// depends on src/hpt_pkg.sv and src/homogeneous_point_transform.sv
`default_nettype none
module tb;
	import hpt_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [REG_IDX_BITS-1:0] wr_index = REG_XX;
	logic [63:0] wr_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [31:0] pt_x = '0;
	logic [31:0] pt_y = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic        zero_divisor;
	logic        overflow;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
	} point_t;

	// shadow copy of the matrix registers, by register index
	logic [63:0] matrix [8];

	point_t pending_points[$];
	res_t   expected_points[$];

	int unsigned requests_taken = 0;
	int unsigned results_taken = 0;
	int unsigned mismatches = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned recv_hold = 0;
	int unsigned send_seen = 0;
	int unsigned recv_seen = 0;

	homogeneous_point_transform dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.push(push), .full(full), .pt_x(pt_x), .pt_y(pt_y),
		.empty(empty), .pop(pop), .out_x(out_x), .out_y(out_y),
		.zero_divisor(zero_divisor), .overflow(overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// safety net against a hung handshake
	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

	// mostly back to back, sometimes short gaps, rarely long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// trunc(num * 2^16 / den) with sign, saturated to the signed 32-bit range
	function automatic logic [31:0] scaled_quotient(logic signed [127:0] num,
			logic signed [127:0] den, ref logic sat);
		logic [127:0] nmag;
		logic [127:0] dmag;
		logic [127:0] q;
		logic [127:0] lim;
		logic         neg;
		nmag = num < 0 ? -num : num;
		dmag = den < 0 ? -den : den;
		neg = (num < 0) != (den < 0);
		q = (nmag << 16) / dmag;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > lim) begin
			q = lim;
			sat = 1'b1;
		end
		return neg ? 32'(-q) : q[31:0];
	endfunction

	function automatic res_t transform_point(logic [31:0] px, logic [31:0] py);
		logic signed [127:0] x, y, z, nx, ny;
		res_t r;
		logic sat;
		x = $signed(px);
		y = $signed(py);
		// homogeneous row, all sums exact
		z = x * $signed(matrix[REG_PP][31:0]) + y * $signed(matrix[REG_PP][63:32])
			+ ($signed(matrix[REG_TT][31:0]) * 128'sd65536);
		r = '0;
		if (z == 0) begin
			r.zero = 1'b1;
			return r;
		end
		nx = x * $signed(matrix[REG_XX][31:0]) + y * $signed(matrix[REG_XY][31:0])
			+ ($signed(matrix[REG_XT][31:0]) * 128'sd65536);
		ny = x * $signed(matrix[REG_YX][31:0]) + y * $signed(matrix[REG_YY][31:0])
			+ ($signed(matrix[REG_YT][31:0]) * 128'sd65536);
		sat = 1'b0;
		r.ox = scaled_quotient(nx, z, sat);
		r.oy = scaled_quotient(ny, z, sat);
		r.ovf = sat;
		return r;
	endfunction

	// request side: take accepted points, queue their predicted results
	always @(posedge clk) begin
		if (push && !full) begin
			expected_points.push_back(transform_point(pt_x, pt_y));
			void'(pending_points.pop_front());
			requests_taken <= requests_taken + 1;
		end
	end

	// result side: compare each popped result with the oldest prediction
	always @(posedge clk) begin
		res_t e;
		if (pop && !empty) begin
			results_taken <= results_taken + 1;
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%h y=%h zero=%b ovf=%b",
						out_x, out_y, zero_divisor, overflow);
			end else begin
				e = expected_points.pop_front();
				if (out_x !== e.ox || out_y !== e.oy || zero_divisor !== e.zero
						|| overflow !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%h y=%h zero=%b ovf=%b, got x=%h y=%h zero=%b ovf=%b",
							e.ox, e.oy, e.zero, e.ovf, out_x, out_y, zero_divisor, overflow);
				end
			end
		end
	end

	// request driver, fed from the pending queue
	always @(negedge clk) begin
		if (requests_taken != send_seen) begin
			send_seen = requests_taken;
			send_gap = pick_gap();
		end
		if (send_gap > 0) begin
			send_gap--;
			push <= 1'b0;
		end else if (pending_points.size() > 0) begin
			push <= 1'b1;
			pt_x <= pending_points[0].x;
			pt_y <= pending_points[0].y;
		end else begin
			push <= 1'b0;
		end
	end

	// result consumer; a long hold lets the block fill up and push back
	always @(negedge clk) begin
		if (results_taken != recv_seen) begin
			recv_seen = results_taken;
			recv_gap = pick_gap();
		end
		if (recv_hold > 0) begin
			recv_hold--;
			pop <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [63:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		matrix[idx] = (idx == REG_PP) ? val : {32'h0, val[31:0]};
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic queue_point(logic [31:0] x, logic [31:0] y);
		point_t p;
		p.x = x;
		p.y = y;
		pending_points.push_back(p);
	endtask

	// let every request drain, then allow for the pipeline depth
	task automatic wait_idle();
		while (pending_points.size() > 0 || expected_points.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// coefficient mix: mostly modest values so quotients stay in range
	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h0;
			2: return 32'h0001_0000;
			3: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_persp();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1, 2: return 32'h0;
			3: return 32'($urandom_range(0, 32'h200)) - 32'h100;
			default: return 32'($urandom_range(0, 32'h20)) - 32'h10;
		endcase
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
			default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
		endcase
	endfunction

	initial begin
		matrix[REG_XX] = 64'h1_0000;
		matrix[REG_XY] = 64'h0;
		matrix[REG_XT] = 64'h0;
		matrix[REG_YX] = 64'h0;
		matrix[REG_YY] = 64'h1_0000;
		matrix[REG_YT] = 64'h0;
		matrix[REG_PP] = 64'h0;
		matrix[REG_TT] = 64'h1_0000;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// identity after reset: coordinate extremes pass through
		queue_point(32'h0, 32'h0);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF);
		queue_point(32'hFFFF_FFFF, 32'h0001_0000);
		queue_point(32'hAAAA_AAAA, 32'h5555_5555);
		wait_idle();

		// z vanishes only at x = 1.0: zero divisor there, ordinary elsewhere
		write_reg(REG_PP, 64'h0000_0000_0001_0000);
		write_reg(REG_TT, 64'hFFFF_0000);
		queue_point(32'h0001_0000, 32'h1234_5678);
		queue_point(32'h0002_0000, 32'h0003_0000);
		queue_point(32'h0000_8000, 32'hFFFF_0000);
		wait_idle();

		// all coefficients at the negative extreme, then the positive one
		for (int i = 0; i < 8; i++)
			write_reg(i[REG_IDX_BITS-1:0], (i == REG_PP) ? 64'h8000_0000_8000_0000
				: 64'h8000_0000);
		queue_point(32'h0001_0000, 32'h0);
		queue_point(32'h8000_0000, 32'h8000_0000);
		queue_point(32'h7FFF_FFFF, 32'h0000_0001);
		queue_point(32'h0, 32'h0);
		wait_idle();
		for (int i = 0; i < 8; i++)
			write_reg(i[REG_IDX_BITS-1:0], (i == REG_PP) ? 64'h7FFF_FFFF_7FFF_FFFF
				: 64'h7FFF_FFFF);
		queue_point(32'h0, 32'h0);
		queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_point(32'h8000_0000, 32'h0000_0001);
		queue_point(32'h0000_0001, 32'hFFFF_FFFF);
		wait_idle();

		// scale by 1000 with tiny z: saturates both ways
		write_reg(REG_XX, 64'h03E8_0000);
		write_reg(REG_XY, 64'h0);
		write_reg(REG_XT, 64'h0);
		write_reg(REG_YX, 64'h0);
		write_reg(REG_YY, 64'hFC18_0000);
		write_reg(REG_YT, 64'h0);
		write_reg(REG_PP, 64'h0);
		write_reg(REG_TT, 64'h0000_0001);
		queue_point(32'h0100_0000, 32'h0100_0000);
		queue_point(32'hFF00_0000, 32'h0000_0001);
		queue_point(32'h0, 32'h0);
		wait_idle();

		// random matrices, about 185 points each
		for (int phase = 0; phase < 10; phase++) begin
			for (int i = 0; i < 8; i++) begin
				if (i == REG_PP)
					write_reg(REG_PP, {pick_persp(), pick_persp()});
				else if (i == REG_TT && phase == 3)
					write_reg(REG_TT, 64'h0);
				else
					write_reg(i[REG_IDX_BITS-1:0], {$urandom(), pick_coef()});
			end
			// receiver stalls long while points keep coming
			if (phase == 2 || phase == 7)
				recv_hold = 400;
			for (int n = 0; n < 185; n++)
				queue_point(pick_coord(), pick_coord());
			wait_idle();
		end

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
